FILE: hdl/okvt_pkg.sv
// ============================================================================
// okvt_pkg: shared types and constants of the ordered key/value table
// Holds the request and status codes, the state type of the sequencer and
// the control word that the top level sends to each storage cell.
// ============================================================================
package okvt_pkg;

    // Fixed payload widths of the request and response channels.
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET    = 2'd0,
        MODE_GET    = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Per-cell command for the execute cycle.
    typedef struct packed {
        logic wr_key;
        logic wr_value;
        logic shift;
    } t_cell_ctl;

endpackage

FILE: hdl/okvt_if.sv
// ============================================================================
// okvt_if: request and response channels of the ordered key/value table
// Valid/ready channels; a transfer happens at a rising clock edge at which
// valid and ready are both high.
// ============================================================================
interface okvt_req_if;
    logic                          valid;
    logic                          ready;
    logic [okvt_pkg::MODE_W-1:0]   mode;
    logic [okvt_pkg::KEY_W-1:0]    key_in;
    logic [okvt_pkg::VALUE_W-1:0]  value_in;

    modport source (output valid, output mode, output key_in, output value_in,
                    input ready);
    modport sink   (input valid, input mode, input key_in, input value_in,
                    output ready);
endinterface

interface okvt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [okvt_pkg::STATUS_W-1:0] status;
    logic [okvt_pkg::VALUE_W-1:0]  value_out;
    logic [okvt_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output value_out,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input value_out,
                    input entry_count, output ready);
endinterface

FILE: hdl/okvt_cell.sv
// ============================================================================
// okvt_cell: one storage cell of the ordered key/value table
// Holds one key and value, compares its key with the broadcast search key,
// and on a delete takes over the contents of its upper neighbor.
// ============================================================================
module okvt_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_valid,
    input  logic [KEY_BITS-1:0]   i_cmp_key,
    input  okvt_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [KEY_BITS-1:0]   i_nb_key,
    input  logic [VALUE_BITS-1:0] i_nb_value,
    output logic                  o_hit,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_nb_key;
            r_value <= i_nb_value;
        end else begin
            if (i_ctl.wr_key) begin
                r_key <= i_key;
            end
            if (i_ctl.wr_value) begin
                r_value <= i_value;
            end
        end
    end

    assign o_hit   = i_valid && (r_key == i_cmp_key);
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

FILE: hdl/ordered_key_value_table.sv
// ============================================================================
// ordered_key_value_table: small associative table in insertion order
// Row of key/value cells with a broadcast compare, in-place update, append
// and shift-down compaction on delete.
// ============================================================================
// Usage:
// Requests arrive on i_req (mode, key_in, value_in) and each one produces
// exactly one result on o_rsp (status, value_out, entry_count). Modes are
// set, get, delete and clear. A set of a new key into a full table is
// refused with the full status and leaves the table unchanged.
//
// Each request has a transfer cycle, in which the request is registered,
// and an execute cycle, in which every cell compares its key with the
// request key in parallel and the update (write, append, or shift of all
// cells above the hit by one place) is applied and the result is loaded
// into an output register. The request port is not ready during the
// execute cycle, so a new request is taken only after the last one has
// executed, since the cell row does a single parallel compare and update.
//
// When the receiver stalls, the result waits in the output register and a
// further request can still be taken; it then waits in the execute cycle
// until the output register frees up. Synchronous active-low reset empties
// the table at once: validity follows from the fill level, so the cells
// need no clearing pass and start with undefined contents.
// ============================================================================
module ordered_key_value_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    okvt_req_if.sink   i_req,
    okvt_rsp_if.source o_rsp
);

    // Fill level needs to hold CAPACITY itself.
    localparam int FW = $clog2(CAPACITY + 1);

    okvt_pkg::t_state      r_state, n_state;
    okvt_pkg::t_mode       r_mode;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [FW-1:0]         r_fill, n_fill;

    logic                                r_out_valid;
    okvt_pkg::t_status                   r_status, n_status;
    logic [okvt_pkg::VALUE_W-1:0]        r_vout, n_vout;
    logic [okvt_pkg::COUNT_W-1:0]        r_count;

    logic                  go;
    logic [63:0]           key_ext;
    logic [KEY_BITS-1:0]   key_red;
    logic [63:0]           val_ext;
    logic [VALUE_BITS-1:0] val_red;
    logic [63:0]           vsel_ext;
    logic [31:0]           fill_ext;

    // Cell row signals.
    logic [CAPACITY-1:0]   hit;
    logic [CAPACITY-1:0]   hit_at_or_below;
    logic                  found;
    logic [VALUE_BITS-1:0] vsel;
    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    okvt_pkg::t_cell_ctl   ctl        [CAPACITY];

    // Request fields are reduced to the configured key and value widths.
    assign key_ext = 64'(i_req.key_in);
    assign key_red = key_ext[KEY_BITS-1:0];
    assign val_ext = 64'(i_req.value_in);
    assign val_red = val_ext[VALUE_BITS-1:0];

    assign i_req.ready = (r_state == okvt_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_mode  <= okvt_pkg::t_mode'(i_req.mode);
            r_key   <= key_red;
            r_value <= val_red;
        end
    end

    // The row of cells. A cell is valid when its index is below the fill
    // level; the top cell has no upper neighbor and just keeps its contents
    // on a shift, since it becomes invalid anyway.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0]   nb_key;
        logic [VALUE_BITS-1:0] nb_value;

        if (g + 1 < CAPACITY) begin : g_nb
            assign nb_key   = cell_key[g+1];
            assign nb_value = cell_value[g+1];
        end else begin : g_top
            assign nb_key   = cell_key[g];
            assign nb_value = cell_value[g];
        end

        okvt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_valid    (FW'(g) < r_fill),
            .i_cmp_key  (r_key),
            .i_ctl      (ctl[g]),
            .i_key      (r_key),
            .i_value    (r_value),
            .i_nb_key   (nb_key),
            .i_nb_value (nb_value),
            .o_hit      (hit[g]),
            .o_key      (cell_key[g]),
            .o_value    (cell_value[g])
        );
    end

    // Keys are unique among valid cells, so at most one cell hits and the
    // read value is a plain AND-OR over the row.
    assign found = |hit;

    always_comb begin
        vsel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            vsel = vsel | ({VALUE_BITS{hit[i]}} & cell_value[i]);
            // Shifting left drops every hit above cell i.
            hit_at_or_below[i] = |(hit << (CAPACITY - 1 - i));
        end
    end

    assign vsel_ext = 64'(vsel);

    // Sequencer: each request gets an execute cycle, held while the output
    // register is full and not being drained.
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_status = okvt_pkg::STAT_DONE;
        n_vout   = '0;
        go       = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            ctl[i] = '0;
        end

        case (r_state)
            okvt_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = okvt_pkg::ST_EXEC;
                end
            end
            okvt_pkg::ST_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    go      = 1'b1;
                    n_state = okvt_pkg::ST_IDLE;
                    case (r_mode)
                        okvt_pkg::MODE_SET: begin
                            if (found) begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    ctl[i].wr_value = hit[i];
                                end
                            end else if (r_fill < FW'(CAPACITY)) begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    ctl[i].wr_key   = (r_fill == FW'(i));
                                    ctl[i].wr_value = (r_fill == FW'(i));
                                end
                                n_fill = r_fill + FW'(1);
                            end else begin
                                n_status = okvt_pkg::STAT_FULL;
                            end
                        end
                        okvt_pkg::MODE_GET: begin
                            if (found) begin
                                n_vout = vsel_ext[okvt_pkg::VALUE_W-1:0];
                            end else begin
                                n_status = okvt_pkg::STAT_MISSING;
                            end
                        end
                        okvt_pkg::MODE_DELETE: begin
                            if (found) begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    ctl[i].shift = hit_at_or_below[i];
                                end
                                n_fill = r_fill - FW'(1);
                            end else begin
                                n_status = okvt_pkg::STAT_MISSING;
                            end
                        end
                        okvt_pkg::MODE_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                            n_fill = r_fill;
                        end
                    endcase
                end
            end
            default: begin
                n_state = okvt_pkg::ST_IDLE;
            end
        endcase
    end

    assign fill_ext = 32'(n_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= okvt_pkg::ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_status <= n_status;
            r_vout   <= n_vout;
            r_count  <= fill_ext[okvt_pkg::COUNT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.value_out   = r_vout;
    assign o_rsp.entry_count = r_count;

endmodule

FILE: hdl/okvt_checker.sv
// ============================================================================
// okvt_checker: port-level checks of the ordered key/value table
// Watches the request and response channels and flags violations over time.
// ============================================================================
module okvt_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_req_valid,
    input logic                                i_req_ready,
    input logic                                i_rsp_valid,
    input logic                                i_rsp_ready,
    input logic [okvt_pkg::STATUS_W-1:0]       i_rsp_status,
    input logic [okvt_pkg::VALUE_W-1:0]        i_rsp_value_out,
    input logic [okvt_pkg::COUNT_W-1:0]        i_rsp_entry_count
);

    // A result that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response withdrawn before transfer");

    // A refused set only happens with the table full.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == okvt_pkg::STAT_FULL)
        |-> (i_rsp_entry_count == okvt_pkg::COUNT_W'(CAPACITY)))
        else $error("full status with table not full");

    // Only a successful lookup carries a value.
    a_value_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_value_out != '0)
        |-> (i_rsp_status == okvt_pkg::STAT_DONE))
        else $error("value returned with a failing status");

    // A fresh result is preceded by a request transfer and then the execute cycle.
    a_rsp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(i_req_valid && i_req_ready, 2))
        else $error("response without a matching request");

endmodule

bind ordered_key_value_table okvt_checker #(
    .CAPACITY (CAPACITY)
) u_okvt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_value_out   (o_rsp.value_out),
    .i_rsp_entry_count (o_rsp.entry_count)
);
